FILE: design/hufdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hufdec_pkg
// Shared types and constants of the Huffman tree load and bit decoder unit.
// ----------------------------------------------------------------------------
package hufdec_pkg;

  localparam int unsigned SYM_PORT_W = 8;
  localparam int unsigned QDEPTH     = 2;

  typedef enum logic [1:0] {
    OP_LEAF   = 2'd0,
    OP_BRANCH = 2'd1,
    OP_BIT    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_TREE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BRANCH,
    BK_BIT
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    logic [SYM_PORT_W-1:0] sym;
    logic                  code_bit;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [SYM_PORT_W-1:0] symbol;
    status_e               status;
  } result_t;

endpackage
`default_nettype wire

FILE: design/hufdec_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hufdec_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hufdec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/hufdec_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hufdec_front
// Accepts commands, classifies the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module hufdec_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [1:0]                         mode_i,
  input  wire logic [hufdec_pkg::SYM_PORT_W-1:0]  leaf_symbol_i,
  input  wire logic                               code_bit_i,
  output logic                                    busy_o,
  output hufdec_pkg::item_t                       head_o,
  output logic                                    head_valid_o,
  input  wire logic                               pop_i
);

  localparam int unsigned PW = (hufdec_pkg::QDEPTH > 1) ? $clog2(hufdec_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(hufdec_pkg::QDEPTH + 1);

  hufdec_pkg::item_t entry_q [hufdec_pkg::QDEPTH];
  hufdec_pkg::item_t item;
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  always_comb begin
    item.sym      = leaf_symbol_i;
    item.code_bit = code_bit_i;
    case (mode_i)
      hufdec_pkg::OP_LEAF:   item.op = hufdec_pkg::OP_LEAF;
      hufdec_pkg::OP_BRANCH: item.op = hufdec_pkg::OP_BRANCH;
      hufdec_pkg::OP_BIT:    item.op = hufdec_pkg::OP_BIT;
      default:               item.op = hufdec_pkg::OP_CLEAR;
    endcase
  end

  assign busy_o       = (cnt_q == CW'(hufdec_pkg::QDEPTH));
  assign push         = start_i && !busy_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(hufdec_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(hufdec_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

FILE: design/hufdec_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hufdec_back
// Executes queued commands: tree build on the stack and node table, and the
// code bit walk. The top of stack node and the current walk node keep their
// children in registers, so each bit needs a single node table read.
// ----------------------------------------------------------------------------
module hufdec_back #(
  parameter int unsigned MAX_NODES   = 512,
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hufdec_pkg::item_t  head_i,
  input  wire logic               head_valid_i,
  output logic                    pop_o,
  output hufdec_pkg::result_t     result_o
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned NC_W   = $clog2(MAX_NODES + 1);
  localparam int unsigned SA_W   = $clog2(STACK_DEPTH);
  localparam int unsigned SC_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SYM_W  =
    (SYMBOL_BITS < hufdec_pkg::SYM_PORT_W) ? SYMBOL_BITS : hufdec_pkg::SYM_PORT_W;
  localparam int unsigned WORD_W = 1 + SYM_W + 2 * NODE_W;

  hufdec_pkg::back_state_e state_q, state_d;

  logic [NC_W-1:0]   node_cnt_q, node_cnt_d;
  logic [SC_W-1:0]   stk_cnt_q, stk_cnt_d;
  logic [NODE_W-1:0] top_idx_q, top_idx_d, top_l_q, top_l_d, top_r_q, top_r_d;
  logic              top_leaf_q, top_leaf_d;
  logic [NODE_W-1:0] walk_l_q, walk_l_d, walk_r_q, walk_r_d;
  logic              walk_act_q, walk_act_d;
  hufdec_pkg::result_t res_q, res_d;

  logic              node_we, node_re;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  logic [WORD_W-1:0] node_wdata, node_rdata;
  logic              stk_we, stk_re;
  logic [SA_W-1:0]   stk_waddr, stk_raddr;
  logic [NODE_W-1:0] stk_wdata, stk_rdata;

  logic              node_full, stk_full;
  logic [SC_W-1:0]   stk_m1, stk_m2;
  logic [SYM_W-1:0]  rd_sym;
  logic              rd_leaf;

  hufdec_ram #(.WIDTH(WORD_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  hufdec_ram #(.WIDTH(NODE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign node_full = (node_cnt_q >= NC_W'(MAX_NODES));
  assign stk_full  = (stk_cnt_q >= SC_W'(STACK_DEPTH));
  assign stk_m1    = stk_cnt_q - SC_W'(1);
  assign stk_m2    = stk_cnt_q - SC_W'(2);
  assign rd_leaf   = node_rdata[WORD_W-1];
  assign rd_sym    = node_rdata[WORD_W-2 -: SYM_W];

  always_comb begin
    state_d    = state_q;
    node_cnt_d = node_cnt_q;
    stk_cnt_d  = stk_cnt_q;
    top_idx_d  = top_idx_q;
    top_l_d    = top_l_q;
    top_r_d    = top_r_q;
    top_leaf_d = top_leaf_q;
    walk_l_d   = walk_l_q;
    walk_r_d   = walk_r_q;
    walk_act_d = walk_act_q;
    res_d      = '{valid: 1'b0, symbol: '0, status: hufdec_pkg::ST_OK};
    pop_o      = 1'b0;
    node_we    = 1'b0;
    node_waddr = node_cnt_q[NODE_W-1:0];
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = stk_m1[SA_W-1:0];
    stk_wdata  = top_idx_q;
    stk_re     = 1'b0;
    stk_raddr  = stk_m2[SA_W-1:0];

    case (state_q)
      hufdec_pkg::BK_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            hufdec_pkg::OP_LEAF: begin
              if (node_full || stk_full) begin
                res_d.valid  = 1'b1;
                res_d.status = hufdec_pkg::ST_FULL;
              end else begin
                node_we    = 1'b1;
                node_wdata = {1'b1, head_i.sym[SYM_W-1:0], {(2 * NODE_W){1'b0}}};
                stk_we     = (stk_cnt_q != '0);
                top_idx_d  = node_cnt_q[NODE_W-1:0];
                top_leaf_d = 1'b1;
                stk_cnt_d  = stk_cnt_q + 1'b1;
                node_cnt_d = node_cnt_q + 1'b1;
                walk_act_d = 1'b0;
              end
            end
            hufdec_pkg::OP_BRANCH: begin
              if (stk_cnt_q < SC_W'(2)) begin
                res_d.valid  = 1'b1;
                res_d.status = hufdec_pkg::ST_UNDERFLOW;
              end else if (node_full) begin
                res_d.valid  = 1'b1;
                res_d.status = hufdec_pkg::ST_FULL;
              end else begin
                stk_re  = 1'b1;
                state_d = hufdec_pkg::BK_BRANCH;
              end
            end
            hufdec_pkg::OP_BIT: begin
              if (stk_cnt_q == '0 || top_leaf_q) begin
                res_d.valid  = 1'b1;
                res_d.status = hufdec_pkg::ST_NO_TREE;
              end else begin
                node_re = 1'b1;
                if (walk_act_q) begin
                  node_raddr = head_i.code_bit ? walk_r_q : walk_l_q;
                end else begin
                  node_raddr = head_i.code_bit ? top_r_q : top_l_q;
                end
                state_d = hufdec_pkg::BK_BIT;
              end
            end
            default: begin
              stk_cnt_d  = '0;
              node_cnt_d = '0;
              walk_act_d = 1'b0;
            end
          endcase
        end
      end
      hufdec_pkg::BK_BRANCH: begin
        node_we    = 1'b1;
        node_wdata = {1'b0, {SYM_W{1'b0}}, stk_rdata, top_idx_q};
        top_l_d    = stk_rdata;
        top_r_d    = top_idx_q;
        top_idx_d  = node_cnt_q[NODE_W-1:0];
        top_leaf_d = 1'b0;
        stk_cnt_d  = stk_m1;
        node_cnt_d = node_cnt_q + 1'b1;
        walk_act_d = 1'b0;
        state_d    = hufdec_pkg::BK_IDLE;
      end
      hufdec_pkg::BK_BIT: begin
        if (rd_leaf) begin
          res_d.valid  = 1'b1;
          res_d.symbol = hufdec_pkg::SYM_PORT_W'(rd_sym);
          res_d.status = hufdec_pkg::ST_OK;
          walk_act_d   = 1'b0;
        end else begin
          walk_l_d   = node_rdata[2*NODE_W-1:NODE_W];
          walk_r_d   = node_rdata[NODE_W-1:0];
          walk_act_d = 1'b1;
        end
        state_d = hufdec_pkg::BK_IDLE;
      end
      default: begin
        state_d = hufdec_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hufdec_pkg::BK_IDLE;
      node_cnt_q <= '0;
      stk_cnt_q  <= '0;
      top_leaf_q <= 1'b0;
      walk_act_q <= 1'b0;
      res_q      <= '{valid: 1'b0, symbol: '0, status: hufdec_pkg::ST_OK};
    end else begin
      state_q    <= state_d;
      node_cnt_q <= node_cnt_d;
      stk_cnt_q  <= stk_cnt_d;
      top_leaf_q <= top_leaf_d;
      walk_act_q <= walk_act_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_idx_q <= top_idx_d;
    top_l_q   <= top_l_d;
    top_r_q   <= top_r_d;
    walk_l_q  <= walk_l_d;
    walk_r_q  <= walk_r_d;
  end

  assign result_o = res_q;

`ifndef SYNTH
  a_branch_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hufdec_pkg::BK_BRANCH |-> stk_cnt_q >= SC_W'(2))
    else $error("branch completion with fewer than two stacked nodes");

  a_walk_has_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_act_q |-> (stk_cnt_q != '0) && !top_leaf_q)
    else $error("walk active without a usable tree");

  a_symbol_from_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid && res_q.status == hufdec_pkg::ST_OK |-> $past(state_q == hufdec_pkg::BK_BIT))
    else $error("decoded symbol not preceded by a node read");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_cnt_q <= NC_W'(MAX_NODES))
    else $error("node count beyond table size");

  a_multi_cycle_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != hufdec_pkg::BK_IDLE |=> state_q == hufdec_pkg::BK_IDLE)
    else $error("back end stuck in a wait state");
`endif

endmodule
`default_nettype wire

FILE: design/huffman_tree_load_and_bit_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_load_and_bit_decoder_unit
// Builds a Huffman tree from postorder leaf/branch tokens and decodes code
// bits against it.
// ----------------------------------------------------------------------------
// A command transfers on a clock edge with start_i high and busy_o low; a
// two-entry command queue sits in front of the execution unit, so busy_o only
// rises when that queue is full. Leaf tokens, clear commands and all error
// cases end in the idle state; a branch token also uses the branch state (the
// second stacked node is read from the stack RAM), a code bit the bit state
// (one node table read). A result, if any, is shown with result_valid_o for a
// single cycle, in the cycle after the command ends; it cannot be held off.
// The node table and stack start undefined and need no clearing after reset.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_bit_decoder_unit #(
  parameter int unsigned MAX_NODES   = 512,
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         mode_i,
  input  wire logic [hufdec_pkg::SYM_PORT_W-1:0]  leaf_symbol_i,
  input  wire logic                               code_bit_i,
  output logic                                    result_valid_o,
  output logic [hufdec_pkg::SYM_PORT_W-1:0]       out_symbol_o,
  output logic [1:0]                              status_o
);

  hufdec_pkg::item_t   head;
  logic                head_valid, pop;
  hufdec_pkg::result_t result;

  hufdec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .mode_i        (mode_i),
    .leaf_symbol_i (leaf_symbol_i),
    .code_bit_i    (code_bit_i),
    .busy_o        (busy_o),
    .head_o        (head),
    .head_valid_o  (head_valid),
    .pop_i         (pop)
  );

  hufdec_back #(
    .MAX_NODES   (MAX_NODES),
    .STACK_DEPTH (STACK_DEPTH),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .result_o     (result)
  );

  assign result_valid_o = result.valid;
  assign out_symbol_o   = result.symbol;
  assign status_o       = result.status;

endmodule
`default_nettype wire
